FILE: src/sfi_pkg.sv
// ----------------------------------------------------------------------------
// Star fractal iterator package
// Payload types, register indexes, vertex ROM and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package sfi_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_COUNT  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_WEIGHT = 2'd1;

	localparam logic [61:0] QCAP  = 62'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [61:0] QCAP3 = 62'(QCAP / 3);

	typedef struct packed {
		logic [15:0] random_word;
	} draw_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic               saturated;
	} point_t;

	typedef struct packed {
		logic               ovf;
		logic signed [31:0] val;
	} clamp_t;

	localparam int ROM_DEPTH = 52;

	localparam logic signed [31:0] K_H    = 32'sd536870912;
	localparam logic signed [31:0] K_O    = 32'sd1073741824;
	localparam logic signed [31:0] K_S3   = 32'sd929887697;
	localparam logic signed [31:0] K_R2   = 32'sd759250125;
	localparam logic signed [31:0] K_C72  = 32'sd331804471;
	localparam logic signed [31:0] K_S72  = 32'sd1021189159;
	localparam logic signed [31:0] K_C36  = 32'sd868675383;
	localparam logic signed [31:0] K_S36  = 32'sd631129609;
	localparam logic signed [31:0] K_C7A  = 32'sd669467077;
	localparam logic signed [31:0] K_S7A  = 32'sd839485162;
	localparam logic signed [31:0] K_C7B  = 32'sd238930034;
	localparam logic signed [31:0] K_S7B  = 32'sd1046820875;
	localparam logic signed [31:0] K_C7C  = 32'sd967407956;
	localparam logic signed [31:0] K_S7C  = 32'sd465879117;
	localparam logic signed [31:0] K_C40  = 32'sd822533958;
	localparam logic signed [31:0] K_S40  = 32'sd690186940;
	localparam logic signed [31:0] K_C80  = 32'sd186453311;
	localparam logic signed [31:0] K_S80  = 32'sd1057429273;
	localparam logic signed [31:0] K_C160 = 32'sd1008987269;
	localparam logic signed [31:0] K_S160 = 32'sd367241333;
	localparam logic signed [31:0] K_Z    = 32'sd0;

	localparam logic signed [31:0] ROM_COS [ROM_DEPTH] = '{
		K_O, -K_H, -K_H,
		K_O, K_Z, -K_O, K_Z,
		K_O, K_C72, -K_C36, -K_C36, K_C72,
		K_O, K_H, -K_H, -K_O, -K_H, K_H,
		K_O, K_C7A, -K_C7B, -K_C7C, -K_C7C, -K_C7B, K_C7A,
		K_O, K_R2, K_Z, -K_R2, -K_O, -K_R2, K_Z, K_R2,
		K_O, K_C40, K_C80, -K_H, -K_C160, -K_C160, -K_H, K_C80, K_C40,
		K_O, K_C36, K_C72, -K_C72, -K_C36, -K_O, -K_C36, -K_C72, K_C72, K_C36
	};

	localparam logic signed [31:0] ROM_SIN [ROM_DEPTH] = '{
		K_Z, K_S3, -K_S3,
		K_Z, K_O, K_Z, -K_O,
		K_Z, K_S72, K_S36, -K_S36, -K_S72,
		K_Z, K_S3, K_S3, K_Z, -K_S3, -K_S3,
		K_Z, K_S7A, K_S7B, K_S7C, -K_S7C, -K_S7B, -K_S7A,
		K_Z, K_R2, K_O, K_R2, K_Z, -K_R2, -K_O, -K_R2,
		K_Z, K_S40, K_S80, K_S3, K_S160, -K_S160, -K_S3, -K_S80, -K_S40,
		K_Z, K_S36, K_S72, K_S72, K_S36, K_Z, -K_S36, -K_S72, -K_S72, -K_S36
	};

	function automatic logic [5:0] rom_base(input logic [3:0] m);
		logic [5:0] b;
		unique case (m)
			4'd4:    b = 6'd3;
			4'd5:    b = 6'd7;
			4'd6:    b = 6'd12;
			4'd7:    b = 6'd18;
			4'd8:    b = 6'd25;
			4'd9:    b = 6'd33;
			4'd10:   b = 6'd42;
			default: b = 6'd0;
		endcase
		return b;
	endfunction

	function automatic clamp_t clamp32(input logic signed [65:0] v);
		clamp_t c;
		if (v > 66'sh0_7FFF_FFFF) begin
			c.ovf = 1'b1;
			c.val = 32'sh7FFF_FFFF;
		end else if (v < -66'sh0_8000_0000) begin
			c.ovf = 1'b1;
			c.val = -32'sh8000_0000;
		end else begin
			c.ovf = 1'b0;
			c.val = v[31:0];
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: src/sfi_stream_if.sv
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfi_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/sfi_divider.sv
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division of mag * 2^(2*FRAC_BITS) by den, one quotient bit per
// cycle, with an optional divide-by-three folded onto the quotient stream.
// ----------------------------------------------------------------------------
`default_nettype none

module sfi_divider #(
	parameter int FRAC_BITS = 24
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire         third,
	input  wire  [31:0] mag,
	input  wire  [63:0] den,
	output logic        done,
	output logic [61:0] quo
);
	import sfi_pkg::*;

	localparam int N  = 32 + 2 * FRAC_BITS;
	localparam int CW = $clog2(N);

	logic          run_q, done_q, over_q, third_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   num_q;
	logic [63:0]   rem_q, den_q;
	logic [61:0]   q_q, q3_q;
	logic [1:0]    r3_q;

	logic [64:0] trial, diff;
	logic        ge, low;
	logic [2:0]  t3;
	logic        g3;

	always_comb begin
		trial = {rem_q, num_q[31]};
		ge    = trial >= {1'b0, den_q};
		diff  = ge ? (trial - {1'b0, den_q}) : trial;
		low   = cnt_q < CW'(62);
		t3    = {r3_q, ge};
		g3    = t3 >= 3'd3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(N - 1);
		end else if (run_q) begin
			if (cnt_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q   <= mag;
			rem_q   <= '0;
			den_q   <= den;
			q_q     <= '0;
			q3_q    <= '0;
			r3_q    <= '0;
			over_q  <= (den == '0);
			third_q <= third;
		end else if (run_q) begin
			num_q <= {num_q[30:0], 1'b0};
			rem_q <= diff[63:0];
			if (low) begin
				q_q  <= {q_q[60:0], ge};
				q3_q <= {q3_q[60:0], g3};
				r3_q <= g3 ? 2'(t3 - 3'd3) : t3[1:0];
			end else if (ge) begin
				over_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign quo  = over_q ? (third_q ? QCAP3 : QCAP) : (third_q ? q3_q : q_q);

endmodule

`default_nettype wire

FILE: src/sfi_target.sv
// ----------------------------------------------------------------------------
// Target selector
// Reduces the random word modulo 2m one bit per cycle, then looks up the
// vertex or edge midpoint in the ROM and converts it to the point format.
// ----------------------------------------------------------------------------
`default_nettype none

module sfi_target #(
	parameter int FRAC_BITS = 24
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire  [15:0]              word,
	input  wire  [3:0]               m,
	output logic                     valid,
	output logic signed [FRAC_BITS+1:0] tx,
	output logic signed [FRAC_BITS+1:0] ty
);
	import sfi_pkg::*;

	localparam int TW  = FRAC_BITS + 2;
	localparam int SR0 = (FRAC_BITS <= 30) ? 30 - FRAC_BITS : 0;
	localparam int SL0 = (FRAC_BITS > 30) ? FRAC_BITS - 30 : 0;
	localparam int SR1 = (FRAC_BITS <= 31) ? 31 - FRAC_BITS : 0;
	localparam int SL1 = (FRAC_BITS > 31) ? FRAC_BITS - 31 : 0;

	logic        run_q, look_q, valid_q;
	logic [3:0]  cnt_q, m_q;
	logic [15:0] word_q;
	logic [4:0]  rem_q;

	logic [5:0]         t, two_m;
	logic [3:0]         i, k1;
	logic [5:0]         idx1, idx0;
	logic signed [32:0] vx, vy;
	logic [63:0]        mx, my;
	logic [TW-1:0]      rx, ry;

	always_comb begin
		two_m = {1'b0, m_q, 1'b0};
		t     = {rem_q, word_q[15]};
		if (t >= two_m) begin
			t = t - two_m;
		end
		i    = rem_q[4:1];
		k1   = (i + 4'd1 == m_q) ? 4'd0 : i + 4'd1;
		idx1 = rom_base(m_q) + {2'b00, k1};
		idx0 = rom_base(m_q) + {2'b00, i};
		if (!rem_q[0]) begin
			vx = 33'(ROM_COS[idx1]);
			vy = 33'(ROM_SIN[idx1]);
		end else begin
			vx = 33'(ROM_COS[idx1]) + 33'(ROM_COS[idx0]);
			vy = 33'(ROM_SIN[idx1]) + 33'(ROM_SIN[idx0]);
		end
		mx = 64'(vx[32] ? -vx : vx);
		my = 64'(vy[32] ? -vy : vy);
		if (!rem_q[0]) begin
			mx = (mx >> SR0) << SL0;
			my = (my >> SR0) << SL0;
		end else begin
			mx = (mx >> SR1) << SL1;
			my = (my >> SR1) << SL1;
		end
		rx = vx[32] ? TW'(-mx) : TW'(mx);
		ry = vy[32] ? TW'(-my) : TW'(my);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			look_q  <= 1'b0;
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (start) begin
			run_q   <= 1'b1;
			look_q  <= 1'b0;
			valid_q <= 1'b0;
			cnt_q   <= 4'd15;
		end else if (run_q) begin
			cnt_q <= cnt_q - 4'd1;
			if (cnt_q == 4'd0) begin
				run_q  <= 1'b0;
				look_q <= 1'b1;
			end
		end else if (look_q) begin
			look_q  <= 1'b0;
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			word_q <= word;
			rem_q  <= '0;
			m_q    <= m;
		end else if (run_q) begin
			word_q <= {word_q[14:0], 1'b0};
			rem_q  <= t[4:0];
		end else if (look_q) begin
			tx <= rx;
			ty <= ry;
		end
	end

	assign valid = valid_q;

endmodule

`default_nettype wire

FILE: src/star_fractal_inversion_iterator.sv
// ----------------------------------------------------------------------------
// Star fractal inversion iterator
// Chaos-game step z = 1 / (conj(1/z)/3 + target) on a fed-back Q8.24 point.
// ----------------------------------------------------------------------------
// Each accepted word advances the point one step and yields one result word.
// Each inversion is one bit-serial divider pass that runs x and y in
// parallel; the block takes a new word once the previous result sits in
// the output register.
`default_nettype none

module star_fractal_inversion_iterator #(
	parameter int FRAC_BITS    = 24,
	parameter int MAX_VERTICES = 10
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [sfi_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire  [sfi_pkg::CFG_DATA_W-1:0]    cfg_data,
	sfi_stream_if.sink                        draw,
	sfi_stream_if.source                      point
);
	import sfi_pkg::*;

	localparam int TW    = FRAC_BITS + 2;
	localparam int TOP_V = (MAX_VERTICES < 10) ? MAX_VERTICES : 10;
	localparam int TOP_C = (TOP_V < 3) ? 3 : TOP_V;
	localparam logic signed [31:0] ONE =
		(FRAC_BITS >= 31) ? 32'sh7FFF_FFFF : 32'(64'd1 << FRAC_BITS);

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_SQA  = 10'b00_0000_0010,
		S_SQB  = 10'b00_0000_0100,
		S_SQC  = 10'b00_0000_1000,
		S_DST  = 10'b00_0001_0000,
		S_DWT  = 10'b00_0010_0000,
		S_ADD  = 10'b00_0100_0000,
		S_SCA  = 10'b00_1000_0000,
		S_SCB  = 10'b01_0000_0000,
		S_OUT  = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	logic   second_q, sat_q, rv_q;
	logic [3:0]         vc_q;
	logic signed [31:0] wt_q;
	logic signed [31:0] px_q, py_q, opa_q, opb_q, ox_q;
	logic signed [63:0] mul_q;
	logic [63:0]        r_q;
	point_t             rdata_q;

	logic [3:0]         m_eff;
	logic signed [31:0] mul_a, mul_b;
	logic               done_a, done_b, tgt_valid;
	logic [61:0]        quo_a, quo_b;
	logic signed [TW-1:0] tx, ty;
	logic signed [65:0] sa, sb;
	clamp_t             ca, cb, cs;
	logic [63:0]        pmag;
	logic signed [65:0] pscaled;
	logic [31:0]        mag_a, mag_b;

	always_comb begin
		if (vc_q < 4'd3) begin
			m_eff = 4'd3;
		end else if (vc_q > 4'(TOP_C)) begin
			m_eff = 4'(TOP_C);
		end else begin
			m_eff = vc_q;
		end
	end

	assign mag_a = opa_q[31] ? 32'(-opa_q) : 32'(opa_q);
	assign mag_b = opb_q[31] ? 32'(-opb_q) : 32'(opb_q);

	sfi_target #(.FRAC_BITS(FRAC_BITS)) u_target (
		.clk   (clk),
		.arst_n(arst_n),
		.start (draw.valid && draw.ready),
		.word  (draw.data.random_word),
		.m     (m_eff),
		.valid (tgt_valid),
		.tx    (tx),
		.ty    (ty)
	);

	sfi_divider #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == S_DST),
		.third (!second_q),
		.mag   (mag_a),
		.den   (r_q),
		.done  (done_a),
		.quo   (quo_a)
	);

	sfi_divider #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == S_DST),
		.third (!second_q),
		.mag   (mag_b),
		.den   (r_q),
		.done  (done_b),
		.quo   (quo_b)
	);

	always_comb begin
		unique case (state_q)
			S_SQA:   begin mul_a = opa_q; mul_b = opa_q; end
			S_SQB:   begin mul_a = opb_q; mul_b = opb_q; end
			S_SCA:   begin mul_a = opa_q; mul_b = wt_q;  end
			default: begin mul_a = opb_q; mul_b = wt_q;  end
		endcase
	end

	always_comb begin
		sa = opa_q[31] ? -66'($unsigned(quo_a)) : 66'($unsigned(quo_a));
		sb = opb_q[31] ? -66'($unsigned(quo_b)) : 66'($unsigned(quo_b));
		if (!second_q) begin
			ca = clamp32(sa + 66'(tx));
			cb = clamp32(-sb + 66'(ty));
		end else begin
			ca = clamp32(sa);
			cb = clamp32(sb);
		end
		pmag    = mul_q[63] ? 64'(-mul_q) : 64'(mul_q);
		pmag    = pmag >> FRAC_BITS;
		pscaled = mul_q[63] ? -66'(pmag) : 66'(pmag);
		cs      = clamp32(pscaled);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= 4'd3;
			wt_q <= 32'sh0100_0000;
		end else if (cfg_we) begin
			if (cfg_index == REG_VERTEX_COUNT) begin
				vc_q <= cfg_data[3:0];
			end else if (cfg_index == REG_OUTPUT_WEIGHT) begin
				wt_q <= cfg_data[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			second_q <= 1'b0;
			rv_q     <= 1'b0;
			px_q     <= ONE;
			py_q     <= ONE;
		end else begin
			if (rv_q && point.ready && state_q != S_OUT) begin
				rv_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (draw.valid) begin
					second_q <= 1'b0;
					state_q  <= S_SQA;
				end
				S_SQA: state_q <= S_SQB;
				S_SQB: state_q <= S_SQC;
				S_SQC: state_q <= S_DST;
				S_DST: state_q <= S_DWT;
				S_DWT: if (done_a) begin
					if (!second_q) begin
						state_q <= S_ADD;
					end else begin
						px_q    <= ca.val;
						py_q    <= cb.val;
						state_q <= S_SCA;
					end
				end
				S_ADD: if (tgt_valid) begin
					second_q <= 1'b1;
					state_q  <= S_SQA;
				end
				S_SCA: state_q <= S_SCB;
				S_SCB: state_q <= S_OUT;
				S_OUT: if (!rv_q || point.ready) begin
					rv_q    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: if (draw.valid) begin
				opa_q <= px_q;
				opb_q <= py_q;
				sat_q <= 1'b0;
			end
			S_SQB: r_q <= 64'(mul_q);
			S_SQC: r_q <= r_q + 64'(mul_q);
			S_DST: if (r_q == '0) begin
				sat_q <= 1'b1;
			end
			S_DWT: if (done_a && second_q) begin
				opa_q <= ca.val;
				opb_q <= cb.val;
				sat_q <= sat_q | ca.ovf | cb.ovf;
			end
			S_ADD: if (tgt_valid) begin
				opa_q <= ca.val;
				opb_q <= cb.val;
				sat_q <= sat_q | ca.ovf | cb.ovf;
			end
			S_SCB: begin
				ox_q  <= cs.val;
				sat_q <= sat_q | cs.ovf;
			end
			S_OUT: if (!rv_q || point.ready) begin
				rdata_q.out_x     <= ox_q;
				rdata_q.out_y     <= cs.val;
				rdata_q.saturated <= sat_q | cs.ovf;
			end
			default: ;
		endcase
	end

	assign draw.ready  = (state_q == S_IDLE);
	assign point.valid = rv_q;
	assign point.data  = rdata_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		draw.valid && draw.ready |=> state_q == S_SQA)
		else $error("Accepted word did not start the squaring pass.");

	a_dividers_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DWT |-> done_a == done_b)
		else $error("The two dividers finished at different cycles.");

	a_target_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ADD |-> tgt_valid)
		else $error("Target lookup was not finished before the first add.");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rv_q) |-> $past(state_q == S_OUT))
		else $error("Result word appeared outside the output state.");

endmodule

`default_nettype wire
